// ----- hdl/pphr_pkg.sv -----
`timescale 1ns / 1ps

package pphr_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 18;
	localparam int DIST_W   = 12;
	localparam int SPM_W    = 16;
	localparam int BPM_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// default sizes
	localparam int RING_DEPTH_DEF     = 128;
	localparam int INTERVAL_SLOTS_DEF = 10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPM      = 1'b1;

	// register reset values
	localparam logic [DIST_W-1:0] MIN_DIST_RST = 12'd30;
	localparam logic [SPM_W-1:0]  SPM_RST      = 16'd6000;

	// rate limits and detection constants
	localparam logic [DIST_W-1:0] SINCE_MAX  = 12'd4095;
	localparam int                BPM_LOW    = 40;
	localparam int                BPM_HIGH   = 200;
	localparam int                AVG_NUM    = 11;
	localparam int                AVG_DEN    = 10;
	localparam logic [1:0]        PEAKS_NEED = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic upd;
		logic mul;
		logic peak;
		logic rng;
		logic div_start;
		logic load_out;
	} pphr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rate_zero;
		logic div_done;
		logic out_free;
	} pphr_status_t;

endpackage

// ----- hdl/pphr_div.sv -----
`timescale 1ns / 1ps

module pphr_div import pphr_pkg::*; #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [BPM_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = (trial >= {1'b0, den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	// rate is range checked before the divide, so it fits the low bits
	assign quotient = quo_q[BPM_W-1:0];
	assign done     = done_q;

endmodule

// ----- hdl/pphr_dp.sv -----
`timescale 1ns / 1ps

module pphr_dp import pphr_pkg::*; #(
	parameter int RING_DEPTH     = RING_DEPTH_DEF,
	parameter int INTERVAL_SLOTS = INTERVAL_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pphr_cmd_t             cmd,
	output pphr_status_t          status,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [SAMPLE_W-1:0]   ir_sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BPM_W-1:0]      beats_per_minute,
	output logic                  peak_found,
	output logic                  ring_ready
);

	localparam int WP_W   = $clog2(RING_DEPTH);
	localparam int SUM_W  = SAMPLE_W + $clog2(RING_DEPTH);
	localparam int CMP_W  = SUM_W + 4;
	localparam int POS_W  = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
	localparam int CNT_W  = $clog2(INTERVAL_SLOTS + 1);
	localparam int ISUM_W = DIST_W + CNT_W;
	localparam int NUM_W  = SPM_W + CNT_W;
	localparam int LIM_W  = ISUM_W + 8;
	localparam int RC_W   = (NUM_W > LIM_W) ? NUM_W : LIM_W;
	localparam int PEAK_K = AVG_DEN * RING_DEPTH;

	// configuration registers
	logic [DIST_W-1:0] min_dist_q;
	logic [SPM_W-1:0]  spm_q;

	// sample ring and detection state
	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] old_q;
	logic [SAMPLE_W-1:0] tap0_q, tap1_q, tap2_q;
	logic [SUM_W-1:0]    sum_q;
	logic [WP_W-1:0]     wp_q;
	logic                filled_q;
	logic [DIST_W-1:0]   since_q;
	logic                seen_q;
	logic [CMP_W-1:0]    lhs_q, rhs_q;
	logic                found_q;

	// interval ring
	logic [DIST_W-1:0]   ival_q [INTERVAL_SLOTS];
	logic [POS_W-1:0]    ipos_q;
	logic [ISUM_W-1:0]   isum_q;
	logic [CNT_W-1:0]    icnt_q;
	logic [1:0]          acc_q;

	// rate terms
	logic [NUM_W-1:0]    num_q;
	logic [LIM_W-1:0]    lo_q, hi_q;
	logic [BPM_W-1:0]    quotient;
	logic                div_done;

	// output register
	logic                out_valid_q;
	logic [BPM_W-1:0]    bpm_q;
	logic                peak_q;
	logic                ready_q;

	logic [SAMPLE_W-1:0] old_val;
	logic                is_peak;
	logic                take_ival;
	logic                rate_zero;

	assign old_val   = filled_q ? old_q : '0;
	assign is_peak   = filled_q && (tap1_q > tap2_q) && (tap1_q > tap0_q) && (lhs_q > rhs_q);
	assign take_ival = seen_q && (since_q >= min_dist_q);
	assign rate_zero = (acc_q < PEAKS_NEED) || (isum_q == '0)
		|| (RC_W'(num_q) < RC_W'(lo_q)) || (RC_W'(num_q) > RC_W'(hi_q));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= MIN_DIST_RST;
			spm_q      <= SPM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MIN_DIST: min_dist_q <= cfg_data[DIST_W-1:0];
				CFG_SPM:      spm_q      <= cfg_data[SPM_W-1:0];
				default:      ;
			endcase
		end
	end

	// sample memory, registered read of the entry about to be replaced
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			old_q <= ring_mem[wp_q];
		end
		if (cmd.upd) begin
			ring_mem[wp_q] <= sample_q;
		end
	end

	// item payload and peak products
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= ir_sample;
		end
		if (cmd.mul) begin
			lhs_q <= CMP_W'(tap1_q) * CMP_W'(PEAK_K);
			rhs_q <= CMP_W'(sum_q) * CMP_W'(AVG_NUM);
		end
		if (cmd.rng) begin
			num_q <= NUM_W'(spm_q) * NUM_W'(icnt_q);
			lo_q  <= LIM_W'(isum_q) * LIM_W'(BPM_LOW);
			hi_q  <= LIM_W'(isum_q) * LIM_W'(BPM_HIGH);
		end
	end

	// ring sum, write position and newest three samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			wp_q     <= '0;
			filled_q <= 1'b0;
			tap0_q   <= '0;
			tap1_q   <= '0;
			tap2_q   <= '0;
		end else if (cmd.upd) begin
			sum_q  <= sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
			tap0_q <= sample_q;
			tap1_q <= tap0_q;
			tap2_q <= tap1_q;
			if (wp_q == WP_W'(RING_DEPTH - 1)) begin
				wp_q     <= '0;
				filled_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// peak interval tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '0;
			seen_q  <= 1'b0;
			found_q <= 1'b0;
			ipos_q  <= '0;
			isum_q  <= '0;
			icnt_q  <= '0;
			acc_q   <= '0;
			for (int i = 0; i < INTERVAL_SLOTS; i++) begin
				ival_q[i] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				found_q <= 1'b0;
			end
			if (cmd.upd && (since_q != SINCE_MAX)) begin
				since_q <= since_q + 1'b1;
			end
			if (cmd.peak && is_peak) begin
				seen_q  <= 1'b1;
				since_q <= '0;
				if (take_ival) begin
					found_q        <= 1'b1;
					isum_q         <= isum_q - ISUM_W'(ival_q[ipos_q]) + ISUM_W'(since_q);
					ival_q[ipos_q] <= since_q;
					if (ipos_q == POS_W'(INTERVAL_SLOTS - 1)) begin
						ipos_q <= '0;
					end else begin
						ipos_q <= ipos_q + 1'b1;
					end
					if (icnt_q != CNT_W'(INTERVAL_SLOTS)) begin
						icnt_q <= icnt_q + 1'b1;
					end
					if (acc_q != PEAKS_NEED) begin
						acc_q <= acc_q + 1'b1;
					end
				end
			end
		end
	end

	pphr_div #(
		.NUM_W (NUM_W),
		.DEN_W (ISUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (num_q),
		.den      (isum_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// output register parts the result from the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			bpm_q   <= rate_zero ? '0 : quotient;
			peak_q  <= found_q;
			ready_q <= filled_q;
		end
	end

	assign status.rate_zero = rate_zero;
	assign status.div_done  = div_done;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign beats_per_minute = bpm_q;
	assign peak_found       = peak_q;
	assign ring_ready       = ready_q;

`ifndef ASSERT_OFF
	a_found_counts: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (acc_q != '0) && (icnt_q != '0))
		else $error("interval flagged without an accepted peak");
	a_icnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		icnt_q <= CNT_W'(INTERVAL_SLOTS))
		else $error("interval count beyond slot count");
	a_found_filled: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> filled_q)
		else $error("interval taken before the ring filled");
	a_since_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.peak && is_peak) |=> (since_q == '0) && seen_q)
		else $error("peak did not restart the interval count");
`endif

endmodule

// ----- hdl/pphr_ctrl.sv -----
`timescale 1ns / 1ps

module pphr_ctrl import pphr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  pphr_status_t status,
	output pphr_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_PEAK = 3'd3;
	localparam logic [2:0] ST_RNG  = 3'd4;
	localparam logic [2:0] ST_CHK  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PEAK;
			end
			ST_PEAK: begin
				cmd.peak = 1'b1;
				state_d  = ST_RNG;
			end
			ST_RNG: begin
				cmd.rng = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (status.rate_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

`ifndef ASSERT_OFF
	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_UPD))
		else $error("accepted sample did not start the update");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free && (state_q == ST_DONE))
		else $error("result loaded over an untaken result");
`endif

endmodule

// ----- hdl/pulse_peak_heart_rate.sv -----
// each sample passes the accept, update, multiply, peak, range and check states,
//   then the 20-step bpm divider (one quotient bit per cycle) when a rate is computed
// a new sample is taken only after the result of the last one is loaded for output
// reset: arst_n clears control, sums, counters and the interval ring at once;
//   the sample ring is tracked by its write position, so no clearing pass runs
`timescale 1ns / 1ps

module pulse_peak_heart_rate import pphr_pkg::*; #(
	parameter int RING_DEPTH     = RING_DEPTH_DEF,
	parameter int INTERVAL_SLOTS = INTERVAL_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [17:0] ir_sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] beats_per_minute, [8] peak_found, [9] ring_ready
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pphr_cmd_t         cmd;
	pphr_status_t      status;
	logic [BPM_W-1:0]  beats_per_minute;
	logic              peak_found;
	logic              ring_ready;

	assign cfg_ready = 1'b1;

	pphr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pphr_dp #(
		.RING_DEPTH     (RING_DEPTH),
		.INTERVAL_SLOTS (INTERVAL_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_valid        (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.ir_sample        (s_tdata[SAMPLE_W-1:0]),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.beats_per_minute (beats_per_minute),
		.peak_found       (peak_found),
		.ring_ready       (ring_ready)
	);

	// pack result fields, zero padded
	assign m_tdata = {{(M_TDATA_W - BPM_W - 2){1'b0}}, ring_ready, peak_found, beats_per_minute};

endmodule

// ----- tb/pulse_peak_heart_rate_tb.sv -----
`timescale 1ns / 1ps

module pulse_peak_heart_rate_tb;
	import pphr_pkg::*;

	localparam int IDLE_PCT     = 14;
	localparam int SETTLE_CYC   = 40;
	localparam int RANDOM_ITEMS = 1560;
	localparam int QUIET_FROM   = 700;
	localparam int QUIET_TO     = 1100;
	localparam int unsigned SAMPLE_LIMIT = (1 << SAMPLE_W) - 1;
	localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;
	localparam logic [DIST_W-1:0]   DIST_TOP   = '1;
	localparam logic [SPM_W-1:0]    SPM_TOP    = '1;

	// one result as it appears in m_tdata[9:0]
	typedef struct packed {
		logic             ring_ready;
		logic             peak_found;
		logic [BPM_W-1:0] bpm;
	} hr_result_t;

	localparam hr_result_t NOT_FILLED = {1'b0, 1'b0, 8'd0};
	localparam hr_result_t NO_PEAK    = {1'b1, 1'b0, 8'd0};
	localparam hr_result_t PEAK_NOW   = {1'b1, 1'b1, 8'd0};
	localparam hr_result_t RATE_TOP   = {1'b1, 1'b1, 8'(BPM_HIGH)};

	typedef enum logic [1:0] {ROW_SAMPLE, ROW_DIST, ROW_RATE} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		int unsigned value;
		int unsigned reps;
		bit          typed;
		hr_result_t  want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit quiet = 1'b0;
	int unsigned mismatches = 0;

	stim_row_t  stim_table[$];
	hr_result_t hr_pending[$];

	// predictor state
	logic [DIST_W-1:0]   dist_reg;
	logic [SPM_W-1:0]    rate_reg;
	logic [SAMPLE_W-1:0] sample_hist [RING_DEPTH_DEF];
	logic [24:0]         hist_sum;
	int unsigned         hist_wr;
	logic                hist_full;
	logic [DIST_W-1:0]   gap_count;
	logic                seen_peak;
	logic [DIST_W-1:0]   gap_hist [INTERVAL_SLOTS_DEF];
	int unsigned         gap_wr;
	logic [15:0]         gap_sum;
	int unsigned         gap_num;
	int unsigned         peak_num;

	pulse_peak_heart_rate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [17:0] ir_sample
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [7:0] beats_per_minute, [8] peak_found, [9] ring_ready
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// guard against a hung block
	initial begin
		#8ms;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		mismatches++;
	endtask

	// rate from the interval ring, zero outside the accepted band
	function automatic logic [BPM_W-1:0] rate_estimate();
		logic [63:0] num;
		if (peak_num < PEAKS_NEED || gap_sum == 0)
			return '0;
		num = 64'(rate_reg) * gap_num;
		if (num < 64'(BPM_LOW) * gap_sum || num > 64'(BPM_HIGH) * gap_sum)
			return '0;
		return BPM_W'(num / gap_sum);
	endfunction

	// advance the predictor by one sample
	task automatic track_heart_rate(input logic [SAMPLE_W-1:0] v, output hr_result_t r);
		logic [SAMPLE_W-1:0] nxt, mid, prv;
		logic [63:0]         lhs, rhs;
		logic                fnd;
		fnd = 1'b0;
		hist_sum = hist_sum - 25'(sample_hist[hist_wr]) + 25'(v);
		sample_hist[hist_wr] = v;
		hist_wr = (hist_wr + 1) % RING_DEPTH_DEF;
		if (hist_wr == 0)
			hist_full = 1'b1;
		if (gap_count < SINCE_MAX)
			gap_count++;
		if (hist_full) begin
			nxt = sample_hist[(hist_wr + RING_DEPTH_DEF - 1) % RING_DEPTH_DEF];
			mid = sample_hist[(hist_wr + RING_DEPTH_DEF - 2) % RING_DEPTH_DEF];
			prv = sample_hist[(hist_wr + RING_DEPTH_DEF - 3) % RING_DEPTH_DEF];
			lhs = 64'(mid) * AVG_DEN * RING_DEPTH_DEF;
			rhs = 64'(hist_sum) * AVG_NUM;
			if (mid > prv && mid > nxt && lhs > rhs) begin
				// first peak only starts the measurement, short gaps are dropped
				if (seen_peak && gap_count >= dist_reg) begin
					gap_sum = gap_sum - 16'(gap_hist[gap_wr]) + 16'(gap_count);
					gap_hist[gap_wr] = gap_count;
					gap_wr = (gap_wr + 1) % INTERVAL_SLOTS_DEF;
					if (gap_num < INTERVAL_SLOTS_DEF)
						gap_num++;
					if (peak_num < PEAKS_NEED)
						peak_num++;
					fnd = 1'b1;
				end
				seen_peak = 1'b1;
				gap_count = '0;
			end
		end
		r.bpm        = rate_estimate();
		r.peak_found = fnd;
		r.ring_ready = hist_full;
	endtask

	// one sample transfer on the slave side
	task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
			input hr_result_t want);
		hr_result_t predicted;
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, v};
		do @(posedge clk); while (!s_tready);
		track_heart_rate(v, predicted);
		hr_pending.push_back(typed ? want : predicted);
	endtask

	// register write transfer
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_MIN_DIST)
			dist_reg = data[DIST_W-1:0];
		else
			rate_reg = data[SPM_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending and let every pending result drain
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (hr_pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	function automatic void add_row(row_kind_e kind, int unsigned value, int unsigned reps = 1,
			bit typed = 1'b0, hr_result_t want = '0);
		stim_table.push_back('{kind, value, reps, typed, want});
	endfunction

	// receiver stalls
	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		hr_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (hr_pending.size() == 0) begin
				report_mismatch("result with no sample pending", 32'(m_tdata), 0);
			end else begin
				want = hr_pending.pop_front();
				if (m_tdata[7:0] !== want.bpm)
					report_mismatch("beats_per_minute", 32'(m_tdata[7:0]), 32'(want.bpm));
				if (m_tdata[8] !== want.peak_found)
					report_mismatch("peak_found", 32'(m_tdata[8]), 32'(want.peak_found));
				if (m_tdata[9] !== want.ring_ready)
					report_mismatch("ring_ready", 32'(m_tdata[9]), 32'(want.ring_ready));
				if (m_tdata[M_TDATA_W-1:10] !== '0)
					report_mismatch("tdata padding", 32'(m_tdata[M_TDATA_W-1:10]), 0);
			end
		end
	end

	initial begin
		int unsigned random_count;
		int unsigned shape, phase_len, period, base, amp, noise_max, level, pos, pick;
		int          cur_period;
		logic [SAMPLE_W-1:0] v;
		logic [DIST_W-1:0]   dist_val;
		logic [SPM_W-1:0]    rate;

		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MIN_DIST;
		cfg_data  = '0;
		arst_n    = 1'b0;

		// predictor reset
		dist_reg  = MIN_DIST_RST;
		rate_reg  = SPM_RST;
		for (int i = 0; i < RING_DEPTH_DEF; i++)
			sample_hist[i] = '0;
		for (int i = 0; i < INTERVAL_SLOTS_DEF; i++)
			gap_hist[i] = '0;
		hist_sum  = '0;
		hist_wr   = 0;
		hist_full = 1'b0;
		gap_count = '0;
		seen_peak = 1'b0;
		gap_wr    = 0;
		gap_sum   = '0;
		gap_num   = 0;
		peak_num  = 0;
		random_count = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table: fill, first peak, short gap, three accepted peaks at the top rate
		add_row(ROW_SAMPLE, 0, RING_DEPTH_DEF - 1, 1'b1, NOT_FILLED);
		add_row(ROW_SAMPLE, 0, 1, 1'b1, NO_PEAK);
		add_row(ROW_SAMPLE, SAMPLE_LIMIT, 1, 1'b1, NO_PEAK);
		add_row(ROW_SAMPLE, 0, 1, 1'b1, NO_PEAK);
		add_row(ROW_SAMPLE, 0, 8, 1'b1, NO_PEAK);
		add_row(ROW_SAMPLE, SAMPLE_LIMIT, 1, 1'b1, NO_PEAK);
		add_row(ROW_SAMPLE, 0, 1, 1'b1, NO_PEAK);
		for (int k = 0; k < 3; k++) begin
			add_row(ROW_SAMPLE, 0, 28, 1'b1, NO_PEAK);
			add_row(ROW_SAMPLE, SAMPLE_LIMIT, 1, 1'b1, NO_PEAK);
			add_row(ROW_SAMPLE, 0, 1, 1'b1, (k == 2) ? RATE_TOP : PEAK_NOW);
		end
		add_row(ROW_SAMPLE, 0, 29);
		add_row(ROW_SAMPLE, SAMPLE_LIMIT);
		add_row(ROW_SAMPLE, 0);
		// zero distance register: a gap of two samples counts
		add_row(ROW_DIST, 0);
		add_row(ROW_SAMPLE, SAMPLE_LIMIT);
		add_row(ROW_SAMPLE, 0);
		// largest distance and rate: a short gap is dropped
		add_row(ROW_DIST, 32'(DIST_TOP));
		add_row(ROW_RATE, 32'(SPM_TOP));
		add_row(ROW_SAMPLE, 5, 40);
		add_row(ROW_SAMPLE, SAMPLE_LIMIT);
		add_row(ROW_SAMPLE, 0);
		// zero rate register
		add_row(ROW_RATE, 0);
		add_row(ROW_DIST, 1);
		add_row(ROW_SAMPLE, 0, 3);
		add_row(ROW_SAMPLE, SAMPLE_LIMIT);
		add_row(ROW_SAMPLE, 0, 1, 1'b1, PEAK_NOW);

		foreach (stim_table[n]) begin
			case (stim_table[n].kind)
				ROW_SAMPLE: begin
					repeat (stim_table[n].reps)
						send_sample(SAMPLE_W'(stim_table[n].value), stim_table[n].typed,
							stim_table[n].want);
				end
				ROW_DIST: begin
					settle();
					write_reg(CFG_MIN_DIST, {4'($urandom), DIST_W'(stim_table[n].value)});
				end
				default: begin
					settle();
					write_reg(CFG_SPM, SPM_W'(stim_table[n].value));
				end
			endcase
		end

		// random phases: mostly pulse trains, some broken trains and raw noise
		while (random_count < RANDOM_ITEMS) begin
			settle();
			if ($urandom_range(0, 1)) begin
				pick = $urandom_range(0, 5);
				case (pick)
					0:       dist_val = '0;
					1:       dist_val = DIST_W'(1);
					2:       dist_val = DIST_TOP;
					default: dist_val = DIST_W'($urandom_range(2, 120));
				endcase
				write_reg(CFG_MIN_DIST, {4'($urandom), dist_val});
			end
			if ($urandom_range(0, 1)) begin
				pick = $urandom_range(0, 6);
				case (pick)
					0:       rate = '0;
					1:       rate = SPM_W'(1);
					2:       rate = SPM_TOP;
					3:       rate = SPM_RST;
					default: rate = SPM_W'($urandom_range(2000, 14000));
				endcase
				write_reg(CFG_SPM, rate);
			end

			shape      = $urandom_range(0, 99);
			phase_len  = $urandom_range(60, 260);
			period     = $urandom_range(2, 160);
			cur_period = period;
			base       = $urandom_range(0, 200000);
			amp        = $urandom_range(500, SAMPLE_LIMIT);
			noise_max  = (shape < 70) ? base / 64 : base / 4 + $urandom_range(0, 2000);
			pos        = $urandom_range(0, period - 1);

			for (int i = 0; i < phase_len; i++) begin
				quiet = (random_count >= QUIET_FROM && random_count < QUIET_TO);
				if (shape >= 85) begin
					v = SAMPLE_W'($urandom_range(0, SAMPLE_LIMIT) >>
						$urandom_range(0, SAMPLE_W - 1));
				end else begin
					level = base + $urandom_range(0, noise_max);
					if (pos == 0) begin
						// broken trains miss a beat now and then
						if (!(shape >= 70 && $urandom_range(0, 4) == 0))
							level += amp;
					end else if (cur_period >= 4 && (pos == 1 || pos == cur_period - 1)) begin
						level += amp / 2;
					end else if (shape >= 70 && $urandom_range(0, 19) == 0) begin
						level += amp;
					end
					v = (level > SAMPLE_LIMIT) ? SAMPLE_TOP : SAMPLE_W'(level);
					pos++;
					if (pos >= cur_period) begin
						pos = 0;
						if (shape >= 70) begin
							cur_period = int'(period) + int'($urandom_range(0, 6)) - 3;
							if (cur_period < 2)
								cur_period = 2;
						end
					end
				end
				send_sample(v, 1'b0, '0);
				random_count++;
			end
		end
		quiet = 1'b0;

		settle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
